// ----- hdl/yrc_pkg.sv -----
// ----------------------------------------------------------------------------
// yrc_pkg
// Shared types and constants for the YCbCr 4:2:0 to RGB converter.
// ----------------------------------------------------------------------------
package yrc_pkg;

    localparam int CFG_DIM_W   = 13;   // width of the image size registers
    localparam int CFG_IDX_W   = 2;
    localparam int ROW_W       = 12;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int QUEUE_DEPTH = 2;

    // BT.601 limited range, coefficients in units of 1/16384
    localparam logic signed [16:0] COEF_Y  = 17'sd19071;
    localparam logic signed [16:0] COEF_RV = 17'sd26149;
    localparam logic signed [16:0] COEF_GV = 17'sd13320;
    localparam logic signed [16:0] COEF_GU = 17'sd6406;
    localparam logic signed [16:0] COEF_BU = 17'sd33063;
    localparam logic [7:0]         LUMA_OFFSET   = 8'd16;
    localparam logic [7:0]         CHROMA_OFFSET = 8'd128;
    localparam logic [7:0]         ALPHA_OPAQUE  = 8'hFF;
    localparam int                 FRAC_BITS     = 14;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_ALPHA_ENABLE = 2'd2
    } cfg_reg_t;

    // classified pixel handed from front to back
    typedef struct packed {
        logic [7:0]  luma;
        logic [7:0]  cr;
        logic [7:0]  cb;
        logic [7:0]  alpha;
        logic        row_end;
        logic        frame_end;
    } pixel_t;

    // products of the first arithmetic stage
    typedef struct packed {
        logic signed [26:0] ys;
        logic signed [26:0] rv;
        logic signed [26:0] gv;
        logic signed [26:0] gu;
        logic signed [26:0] bu;
        logic [7:0]         alpha;
        logic               row_end;
        logic               frame_end;
    } product_t;

    function automatic logic [7:0] clamp_shift(input logic signed [27:0] sum);
        logic [7:0] res;
        if (sum < 0)
            res = 8'd0;
        else if (sum[27:FRAC_BITS+8] != '0)
            res = 8'd255;
        else
            res = sum[FRAC_BITS+7:FRAC_BITS];
        return res;
    endfunction

endpackage

// ----- hdl/yrc_front.sv -----
// ----------------------------------------------------------------------------
// yrc_front
// Configuration registers, raster counters and chroma line store. Classifies
// each pixel and resolves the chroma pair it uses.
// ----------------------------------------------------------------------------
module yrc_front #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [yrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [yrc_pkg::CFG_DIM_W-1:0] cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [31:0]                  in_data,
    output logic                         q_valid,
    input  logic                         q_ready,
    output yrc_pkg::pixel_t              q_item
);
    import yrc_pkg::*;

    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = ($clog2(MAX_WIDTH + 1) > CFG_DIM_W) ? $clog2(MAX_WIDTH + 1)
                                                             : CFG_DIM_W;

    logic [CFG_DIM_W-1:0] width_reg, height_reg;
    logic                 alpha_en_reg;

    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [15:0]      held_chroma_reg, held_chroma_next;

    logic [15:0] line_mem [LINE_DEPTH];
    logic [15:0] line_rd_reg;

    logic        f_valid_reg;
    logic        f_use_line_reg;
    pixel_t      f_item_reg, f_item_next;

    logic [WW-1:0]        width_ext, col_last;
    logic [CFG_DIM_W-1:0] row_last;
    logic                 last_col, last_row;
    logic                 in_fire, sample, even_row;
    logic [AW-1:0]        slot;
    logic [15:0]          new_pair, pair;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= CFG_DIM_W'(4096);
            height_reg   <= CFG_DIM_W'(4096);
            alpha_en_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg    <= cfg_data;
                CFG_IMAGE_HEIGHT: height_reg   <= cfg_data;
                CFG_ALPHA_ENABLE: alpha_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // last column / row indices, with out-of-range sizes folded in
    always_comb
    begin
        width_ext = WW'(width_reg);
        if (width_reg == '0)
            col_last = '0;
        else if (width_ext > WW'(MAX_WIDTH))
            col_last = WW'(MAX_WIDTH - 1);
        else
            col_last = width_ext - 1'b1;

        if (height_reg == '0)
            row_last = '0;
        else if (height_reg > CFG_DIM_W'(HEIGHT_LIMIT))
            row_last = CFG_DIM_W'(HEIGHT_LIMIT - 1);
        else
            row_last = height_reg - 1'b1;
    end

    assign last_col = WW'(col_reg) >= col_last;
    assign last_row = CFG_DIM_W'(row_reg) >= row_last;

    assign in_ready = !f_valid_reg || q_ready;
    assign in_fire  = in_valid && in_ready;
    assign even_row = !row_reg[0];
    assign sample   = even_row && !col_reg[0];
    assign slot     = AW'(col_reg >> 1);
    assign new_pair = {in_data[23:16], in_data[15:8]};

    always_comb
    begin
        col_next         = col_reg;
        row_next         = row_reg;
        held_chroma_next = held_chroma_reg;
        if (in_fire)
        begin
            if (sample)
                held_chroma_next = new_pair;
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end

        f_item_next.luma      = in_data[7:0];
        f_item_next.cb        = held_chroma_next[7:0];
        f_item_next.cr        = held_chroma_next[15:8];
        f_item_next.alpha     = alpha_en_reg ? in_data[31:24] : ALPHA_OPAQUE;
        f_item_next.row_end   = last_col;
        f_item_next.frame_end = last_col && last_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= '0;
            row_reg         <= '0;
            held_chroma_reg <= '0;
            f_valid_reg     <= 1'b0;
        end
        else
        begin
            col_reg         <= col_next;
            row_reg         <= row_next;
            held_chroma_reg <= held_chroma_next;
            if (in_fire)
                f_valid_reg <= 1'b1;
            else if (q_ready)
                f_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            f_item_reg     <= f_item_next;
            f_use_line_reg <= !even_row;
        end
    end

    // even rows fill the store, odd rows read it back
    always_ff @(posedge clk)
    begin
        if (in_fire && sample)
            line_mem[slot] <= new_pair;
        if (in_fire && !even_row)
            line_rd_reg <= line_mem[slot];
    end

    assign pair = f_use_line_reg ? line_rd_reg : {f_item_reg.cr, f_item_reg.cb};

    always_comb
    begin
        q_item    = f_item_reg;
        q_item.cb = pair[7:0];
        q_item.cr = pair[15:8];
    end

    assign q_valid = f_valid_reg;

endmodule

// ----- hdl/yrc_queue.sv -----
// ----------------------------------------------------------------------------
// yrc_queue
// Short FIFO of classified pixels between front and back.
// ----------------------------------------------------------------------------
module yrc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  yrc_pkg::pixel_t wr_item,
    output logic            rd_valid,
    input  logic            rd_ready,
    output yrc_pkg::pixel_t rd_item
);
    import yrc_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    pixel_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]     count_reg;
    logic            push, pop;

    assign wr_ready = count_reg != (PW + 1)'(QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_item  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

// ----- hdl/yrc_back.sv -----
// ----------------------------------------------------------------------------
// yrc_back
// Colour conversion: multiply stage, then sum, floor and clamp into the
// output register.
// ----------------------------------------------------------------------------
module yrc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  yrc_pkg::pixel_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [31:0]     out_pixel,
    output logic            out_row_end,
    output logic            out_frame_end
);
    import yrc_pkg::*;

    logic               s1_valid_reg;
    product_t           s1_reg, s1_next;
    logic               o_valid_reg;
    logic [31:0]        o_data_reg, o_data_next;
    logic               o_row_end_reg, o_frame_end_reg;
    logic               o_ready, s1_ready;
    logic signed [9:0]  yd, ud, vd;
    logic signed [27:0] sum_r, sum_g, sum_b;

    assign o_ready  = !o_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || o_ready;
    assign in_ready = s1_ready;

    always_comb
    begin
        yd = $signed({2'b00, in_item.luma}) - $signed({2'b00, LUMA_OFFSET});
        ud = $signed({2'b00, in_item.cb}) - $signed({2'b00, CHROMA_OFFSET});
        vd = $signed({2'b00, in_item.cr}) - $signed({2'b00, CHROMA_OFFSET});
        s1_next.ys        = 27'(COEF_Y * yd);
        s1_next.rv        = 27'(COEF_RV * vd);
        s1_next.gv        = 27'(COEF_GV * vd);
        s1_next.gu        = 27'(COEF_GU * ud);
        s1_next.bu        = 27'(COEF_BU * ud);
        s1_next.alpha     = in_item.alpha;
        s1_next.row_end   = in_item.row_end;
        s1_next.frame_end = in_item.frame_end;
    end

    always_comb
    begin
        sum_r = 28'(s1_reg.ys) + 28'(s1_reg.rv);
        sum_g = 28'(s1_reg.ys) - 28'(s1_reg.gv) - 28'(s1_reg.gu);
        sum_b = 28'(s1_reg.ys) + 28'(s1_reg.bu);
        o_data_next = {s1_reg.alpha, clamp_shift(sum_b), clamp_shift(sum_g),
                       clamp_shift(sum_r)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (o_ready)
                o_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
            s1_reg <= s1_next;
        if (o_ready && s1_valid_reg)
        begin
            o_data_reg      <= o_data_next;
            o_row_end_reg   <= s1_reg.row_end;
            o_frame_end_reg <= s1_reg.frame_end;
        end
    end

    assign out_valid     = o_valid_reg;
    assign out_pixel     = o_data_reg;
    assign out_row_end   = o_row_end_reg;
    assign out_frame_end = o_frame_end_reg;

endmodule

// ----- hdl/ycbcr420_to_rgb_converter.sv -----
// ----------------------------------------------------------------------------
// ycbcr420_to_rgb_converter
// BT.601 limited-range YCbCr 4:2:0 to RGB with alpha, one pixel per clock while m_axis is ready.
// ----------------------------------------------------------------------------
// Input words on s_axis arrive in raster order. Chroma is taken at even
// rows and even columns, held for the odd column and kept in a line store
// of (MAX_WIDTH+1)/2 entries for reuse on the following odd row.
// Output words on m_axis carry R, G, B and alpha; tlast marks the last pixel
// of a row, tuser the last pixel of the frame.
// Image size and alpha enable are written on the cfg channel, which is
// always ready; write it only while no words are in flight.
// Throughput: one word per clock while m_axis_tready is held. An accepted
// word passes through the front register, queue, multiply stage and output
// register in that order before it is presented on m_axis.
// A stalled receiver holds the output register; the two-entry queue and
// the stage registers fill and s_axis_tready drops only once all are full.
// Reset clears the raster counters and pipeline and restores the defaults
// (4096 x 4096, alpha forced to 255). The line store is not cleared.
// ----------------------------------------------------------------------------
module ycbcr420_to_rgb_converter #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [yrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [yrc_pkg::CFG_DIM_W-1:0] cfg_data,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [31:0]                  s_axis_tdata,   // luma, blue_diff, red_diff, alpha_in
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [31:0]                  m_axis_tdata,   // red, green, blue, alpha_out
    output logic                         m_axis_tlast,
    output logic                         m_axis_tuser    // frame_end
);
    import yrc_pkg::*;

    logic   fq_valid, fq_ready;
    pixel_t fq_item;
    logic   qb_valid, qb_ready;
    pixel_t qb_item;

    yrc_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_item    (fq_item)
    );

    yrc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_item  (fq_item),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_item  (qb_item)
    );

    yrc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (qb_valid),
        .in_ready      (qb_ready),
        .in_item       (qb_item),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_pixel     (m_axis_tdata),
        .out_row_end   (m_axis_tlast),
        .out_frame_end (m_axis_tuser)
    );

endmodule
